// File: hw/rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg : shared types, constants and conversions for the servo slew ramp
// Fixed-point angle format, operation codes, and the duty/angle conversions.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

    // Channel count and field widths
    localparam int CHANNELS        = 4;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int TARGET_W        = 15;
    localparam int ANGLE_W         = 16;
    localparam int DUTY_W          = 10;
    localparam int STEP_W          = 14;

    // pi/2 in Q20, reduced with rounding to the angle format
    localparam int HALF_PI_Q20 = 1647099;
    localparam int HALF_PI_Q   =
        (HALF_PI_Q20 + (1 << (19 - ANGLE_FRAC_BITS))) >>> (20 - ANGLE_FRAC_BITS);

    // Duty reset value and conversion constants
    localparam int DUTY_MID  = 500;
    localparam int DUTY_SPAN = 400;
    localparam int DUTY_MIN  = 100;

    // Rounded-up reciprocal for (mag * HALF_PI_Q) / 400, exact for mag < 1024
    localparam int     D2A_SHIFT = 20;
    localparam longint D2A_MUL   =
        ((longint'(HALF_PI_Q) << D2A_SHIFT) + DUTY_SPAN - 1) / DUTY_SPAN;
    localparam int     D2A_W     = $clog2(D2A_MUL + 1);

    // Rounded-up reciprocal for (400 * u) / HALF_PI_Q, exact for u <= 2*HALF_PI_Q
    localparam int     A2D_SHIFT = 32;
    localparam longint A2D_MUL   =
        ((longint'(DUTY_SPAN) << A2D_SHIFT) + HALF_PI_Q - 1) / HALF_PI_Q;
    localparam int     A2D_W     = $clog2(A2D_MUL + 1);

    localparam logic signed [ANGLE_W-1:0] HALF_PI_S = ANGLE_W'(HALF_PI_Q);

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [DUTY_W-1:0]         duty_t;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ARM  = 2'd0,
        OP_HAND = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    // Duty to angle: (duty - 500) * pi/2 / 400, truncated toward zero
    function automatic angle_t angle_from_duty(input duty_t duty);
        logic signed [DUTY_W:0]       d;
        logic [DUTY_W-1:0]            mag;
        logic [D2A_W+DUTY_W-1:0]      prod;
        logic [ANGLE_W-1:0]           q;
        d    = $signed({1'b0, duty}) - (DUTY_W+1)'(DUTY_MID);
        mag  = d[DUTY_W] ? DUTY_W'(-d) : DUTY_W'(d);
        prod = (D2A_W+DUTY_W)'(mag) * (D2A_W+DUTY_W)'(D2A_MUL);
        q    = ANGLE_W'(prod >> D2A_SHIFT);
        return d[DUTY_W] ? -$signed(q) : $signed(q);
    endfunction

    // Angle to duty: saturate to +-pi/2, then 100 + floor(400 * (a + pi/2) / (pi/2))
    function automatic duty_t duty_from_angle(input angle_t a);
        angle_t                   a_sat;
        logic signed [ANGLE_W:0]  s;
        logic [ANGLE_W-1:0]       u;
        logic [A2D_W+ANGLE_W-1:0] prod;
        logic [DUTY_W-1:0]        n;
        if (a < -HALF_PI_S)
            a_sat = -HALF_PI_S;
        else if (a > HALF_PI_S)
            a_sat = HALF_PI_S;
        else
            a_sat = a;
        s    = {a_sat[ANGLE_W-1], a_sat} + (ANGLE_W+1)'(HALF_PI_Q);
        u    = s[ANGLE_W-1:0];
        prod = (A2D_W+ANGLE_W)'(u) * (A2D_W+ANGLE_W)'(A2D_MUL);
        n    = DUTY_W'(prod >> A2D_SHIFT);
        return DUTY_W'(DUTY_MIN) + n;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/servo_slew_ramp_four_channel_unit.sv
// ----------------------------------------------------------------------------
// servo_slew_ramp_four_channel_unit : four-channel servo slew-rate limiter
// A transaction is captured in the input register, then its result in the
// result register, where it is held while out_stall is high.
// Throughput: one transaction per cycle unless out_stall holds the result; the four
// channel lanes update in parallel in one pass.
// Reset: positions and targets clear to zero, duties to 500, step to 257.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_ramp_four_channel_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [ssr_pkg::STEP_W-1:0]     step_per_tick,
    // input channel
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic [1:0]                     op,
    input  wire logic signed [ssr_pkg::TARGET_W-1:0] target_0,
    input  wire logic signed [ssr_pkg::TARGET_W-1:0] target_1,
    input  wire logic signed [ssr_pkg::TARGET_W-1:0] target_2,
    input  wire logic signed [ssr_pkg::TARGET_W-1:0] target_3,
    // result channel
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic [ssr_pkg::DUTY_W-1:0]     duty_0,
    output      logic [ssr_pkg::DUTY_W-1:0]     duty_1,
    output      logic [ssr_pkg::DUTY_W-1:0]     duty_2,
    output      logic [ssr_pkg::DUTY_W-1:0]     duty_3,
    output      logic                           moving
);

    localparam int NCH = ssr_pkg::CHANNELS;

    // Step register
    logic [ssr_pkg::STEP_W-1:0] step_reg;

    // Input register
    logic                       in_valid_reg;
    logic [1:0]                 op_reg;
    ssr_pkg::angle_t            tgt_in_reg [NCH];

    // Channel state
    ssr_pkg::angle_t            pos_reg  [NCH];
    ssr_pkg::angle_t            tgt_reg  [NCH];
    ssr_pkg::duty_t             duty_reg [NCH];
    ssr_pkg::angle_t            pos_next  [NCH];
    ssr_pkg::angle_t            tgt_next  [NCH];
    ssr_pkg::duty_t             duty_next [NCH];
    logic                       moving_next;

    // Result register
    logic                       out_valid_reg;
    ssr_pkg::duty_t             res_duty_reg [NCH];
    logic                       res_moving_reg;

    logic                       advance;
    logic                       in_accept;

    // Handshake: the pass advances whenever the result register can take a value
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Hold the step setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ssr_pkg::STEP_W'(257);
        else if (cfg_valid && cfg_ready)
            step_reg <= step_per_tick;
    end

    // Capture the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance || !in_valid_reg)
            in_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg        <= op;
            tgt_in_reg[0] <= ssr_pkg::ANGLE_W'(target_0);
            tgt_in_reg[1] <= ssr_pkg::ANGLE_W'(target_1);
            tgt_in_reg[2] <= ssr_pkg::ANGLE_W'(target_2);
            tgt_in_reg[3] <= ssr_pkg::ANGLE_W'(target_3);
        end
    end

    // Work out the next channel state for the held transaction
    always_comb
    begin
        logic [ssr_pkg::STEP_W-1:0]       step_eff;
        logic signed [ssr_pkg::ANGLE_W:0] step_ext;
        logic signed [ssr_pkg::ANGLE_W:0] p_ext;
        logic signed [ssr_pkg::ANGLE_W:0] t_ext;
        logic signed [ssr_pkg::ANGLE_W:0] p_new;
        ssr_pkg::angle_t                  reload [NCH];

        step_eff    = (step_reg == '0) ? ssr_pkg::STEP_W'(1) : step_reg;
        step_ext    = $signed({3'b000, step_eff});
        moving_next = 1'b0;
        p_ext       = '0;
        t_ext       = '0;
        p_new       = '0;

        for (int i = 0; i < NCH; i++)
        begin
            pos_next[i]  = pos_reg[i];
            tgt_next[i]  = tgt_reg[i];
            duty_next[i] = duty_reg[i];
            reload[i]    = ssr_pkg::angle_from_duty(duty_reg[i]);
        end

        case (ssr_pkg::op_t'(op_reg))
            ssr_pkg::OP_ARM:
            begin
                // Reload positions, aim channels 0-2, hold channel 3
                for (int i = 0; i < NCH; i++)
                    pos_next[i] = reload[i];
                for (int i = 0; i < NCH - 1; i++)
                    tgt_next[i] = tgt_in_reg[i];
                tgt_next[NCH-1] = reload[NCH-1];
            end
            ssr_pkg::OP_HAND:
            begin
                // Reload positions, hold channels 0-2, aim channel 3
                for (int i = 0; i < NCH; i++)
                    pos_next[i] = reload[i];
                for (int i = 0; i < NCH - 1; i++)
                    tgt_next[i] = reload[i];
                tgt_next[NCH-1] = tgt_in_reg[NCH-1];
            end
            ssr_pkg::OP_TICK:
            begin
                // Advance each position toward its target without overshoot
                for (int i = 0; i < NCH; i++)
                begin
                    p_ext = {pos_reg[i][ssr_pkg::ANGLE_W-1], pos_reg[i]};
                    t_ext = {tgt_reg[i][ssr_pkg::ANGLE_W-1], tgt_reg[i]};
                    p_new = p_ext;
                    if (p_ext < t_ext)
                    begin
                        p_new = p_ext + step_ext;
                        if (p_new > t_ext)
                            p_new = t_ext;
                        moving_next = 1'b1;
                    end
                    else if (p_ext > t_ext)
                    begin
                        p_new = p_ext - step_ext;
                        if (p_new < t_ext)
                            p_new = t_ext;
                        moving_next = 1'b1;
                    end
                    pos_next[i] = p_new[ssr_pkg::ANGLE_W-1:0];
                end
                // Refresh the duties only when something moved
                if (moving_next)
                begin
                    for (int i = 0; i < NCH; i++)
                        duty_next[i] = ssr_pkg::duty_from_angle(pos_next[i]);
                end
            end
            default:
            begin
                // Drop unused codes: state holds
                moving_next = 1'b0;
            end
        endcase
    end

    // Update channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                pos_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                duty_reg[i] <= ssr_pkg::DUTY_W'(ssr_pkg::DUTY_MID);
            end
        end
        else if (advance && in_valid_reg)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                pos_reg[i]  <= pos_next[i];
                tgt_reg[i]  <= tgt_next[i];
                duty_reg[i] <= duty_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            for (int i = 0; i < NCH; i++)
                res_duty_reg[i] <= duty_next[i];
            res_moving_reg <= moving_next;
        end
    end

    // Drive the result ports
    assign out_valid = out_valid_reg;
    assign duty_0    = res_duty_reg[0];
    assign duty_1    = res_duty_reg[1];
    assign duty_2    = res_duty_reg[2];
    assign duty_3    = res_duty_reg[3];
    assign moving    = res_moving_reg;

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the four-channel servo slew ramp
// Feeds arm, hand, tick and unused commands through a valid/stall driver with
// random gaps, and tracks positions, targets and duties in a local ramp
// model. Every result transaction is checked field by field against the
// oldest predicted duty set. The step register is swept between traffic
// phases, including zero and full scale.
// ----------------------------------------------------------------------------

module tb_top;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STEP_RESET  = 257;
    localparam int         SETTLE_CYC  = 4;
    localparam int         LIMIT_CYC   = 200000;
    localparam int         PHASE_ITEMS = 115;

    typedef logic signed [ssr_pkg::TARGET_W-1:0] target_t;

    typedef struct {
        logic [1:0] op;
        target_t    tgt [ssr_pkg::CHANNELS];
    } servo_cmd_t;

    typedef struct {
        ssr_pkg::duty_t duty [ssr_pkg::CHANNELS];
        logic           moving;
    } duty_set_t;

    // Bench signals
    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [ssr_pkg::STEP_W-1:0] step_per_tick;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 op;
    target_t                    target_0;
    target_t                    target_1;
    target_t                    target_2;
    target_t                    target_3;
    logic                       out_valid;
    logic                       out_stall;
    ssr_pkg::duty_t             duty_0;
    ssr_pkg::duty_t             duty_1;
    ssr_pkg::duty_t             duty_2;
    ssr_pkg::duty_t             duty_3;
    logic                       moving;

    // Handshake flags captured at the rising edge, read at the falling edge
    logic                in_took;
    logic                out_took;
    logic                cfg_took;

    servo_cmd_t          cmd_queue [$];
    duty_set_t           duty_expect_q [$];
    logic                cmd_hold;
    int                  send_wait;
    int                  recv_wait;
    logic                idle_on;
    int                  fault_count;
    int                  cycle_count;

    // Ramp model state
    ssr_pkg::angle_t            ramp_pos [ssr_pkg::CHANNELS];
    ssr_pkg::angle_t            ramp_aim [ssr_pkg::CHANNELS];
    ssr_pkg::duty_t             ramp_duty [ssr_pkg::CHANNELS];
    logic [ssr_pkg::STEP_W-1:0] ramp_step;

    servo_slew_ramp_four_channel_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .step_per_tick (step_per_tick),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .target_0      (target_0),
        .target_1      (target_1),
        .target_2      (target_2),
        .target_3      (target_3),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .duty_0        (duty_0),
        .duty_1        (duty_1),
        .duty_2        (duty_2),
        .duty_3        (duty_3),
        .moving        (moving)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Duty to angle, truncating toward zero
    function automatic ssr_pkg::angle_t duty_to_pos(input ssr_pkg::duty_t dv);
        int d;
        int q;
        d = int'(dv) - ssr_pkg::DUTY_MID;
        q = ((d < 0 ? -d : d) * ssr_pkg::HALF_PI_Q) / ssr_pkg::DUTY_SPAN;
        return ssr_pkg::angle_t'(d < 0 ? -q : q);
    endfunction

    // Angle to duty, saturating at +-pi/2 and flooring
    function automatic ssr_pkg::duty_t pos_to_duty(input ssr_pkg::angle_t a);
        int v;
        v = int'(a);
        if (v < -ssr_pkg::HALF_PI_Q)
            v = -ssr_pkg::HALF_PI_Q;
        else if (v > ssr_pkg::HALF_PI_Q)
            v = ssr_pkg::HALF_PI_Q;
        return ssr_pkg::duty_t'(ssr_pkg::DUTY_MIN
                                + (ssr_pkg::DUTY_SPAN * (v + ssr_pkg::HALF_PI_Q))
                                  / ssr_pkg::HALF_PI_Q);
    endfunction

    // Apply one command to the ramp state and return the duty set it reports
    function automatic duty_set_t servo_advance(input servo_cmd_t c);
        duty_set_t r;
        int        stride;
        int        p;
        int        t;
        r.moving = 1'b0;
        if (c.op == ssr_pkg::OP_ARM || c.op == ssr_pkg::OP_HAND)
        begin
            for (int i = 0; i < ssr_pkg::CHANNELS; i++)
            begin
                ramp_pos[i] = duty_to_pos(ramp_duty[i]);
                ramp_aim[i] = ramp_pos[i];
            end
            if (c.op == ssr_pkg::OP_ARM)
            begin
                for (int i = 0; i < ssr_pkg::CHANNELS - 1; i++)
                    ramp_aim[i] = ssr_pkg::angle_t'(c.tgt[i]);
            end
            else
                ramp_aim[ssr_pkg::CHANNELS-1] = ssr_pkg::angle_t'(c.tgt[ssr_pkg::CHANNELS-1]);
        end
        else if (c.op == ssr_pkg::OP_TICK)
        begin
            stride = (ramp_step == '0) ? 1 : int'(ramp_step);
            for (int i = 0; i < ssr_pkg::CHANNELS; i++)
            begin
                p = int'(ramp_pos[i]);
                t = int'(ramp_aim[i]);
                if (p < t)
                begin
                    p = (p + stride > t) ? t : p + stride;
                    r.moving = 1'b1;
                end
                else if (p > t)
                begin
                    p = (p - stride < t) ? t : p - stride;
                    r.moving = 1'b1;
                end
                ramp_pos[i] = ssr_pkg::angle_t'(p);
            end
            // Only a tick that moved something refreshes the duties
            if (r.moving)
            begin
                for (int i = 0; i < ssr_pkg::CHANNELS; i++)
                    ramp_duty[i] = pos_to_duty(ramp_pos[i]);
            end
        end
        for (int i = 0; i < ssr_pkg::CHANNELS; i++)
            r.duty[i] = ramp_duty[i];
        return r;
    endfunction

    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, 7)) : 0;
    endfunction

    // Bias targets toward the extremes and the saturation corners
    function automatic target_t pick_target();
        case ($urandom_range(0, 6))
            0: return target_t'(-16384);
            1: return target_t'(16383);
            2: return target_t'(ssr_pkg::HALF_PI_Q + int'($urandom_range(0, 4)) - 2);
            3: return target_t'(-ssr_pkg::HALF_PI_Q + int'($urandom_range(0, 4)) - 2);
            4: return target_t'(0);
            default: return target_t'($urandom);
        endcase
    endfunction

    task automatic queue_cmd(input logic [1:0] c_op, input target_t t0, input target_t t1,
                             input target_t t2, input target_t t3);
        servo_cmd_t c;
        c.op     = c_op;
        c.tgt[0] = t0;
        c.tgt[1] = t1;
        c.tgt[2] = t2;
        c.tgt[3] = t3;
        cmd_queue.push_back(c);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n)
            queue_cmd(ssr_pkg::OP_TICK, target_t'($urandom), target_t'($urandom),
                      target_t'($urandom), target_t'($urandom));
    endtask

    // Mostly a command followed by a run of ticks; the rest short runs of one to three ticks and unused ops
    task automatic queue_random_traffic(input int quota);
        int counted;
        int kind;
        int ticks;
        counted = 0;
        while (counted < quota)
        begin
            kind = $urandom_range(0, 9);
            ticks = 0;
            if (kind <= 3)
            begin
                queue_cmd(ssr_pkg::OP_ARM, pick_target(), pick_target(), pick_target(),
                          pick_target());
                counted++;
                ticks = $urandom_range(1, 30);
            end
            else if (kind <= 6)
            begin
                queue_cmd(ssr_pkg::OP_HAND, pick_target(), pick_target(), pick_target(),
                          pick_target());
                counted++;
                ticks = $urandom_range(1, 30);
            end
            else if (kind == 7)
                queue_cmd(OP_UNUSED, target_t'($urandom), target_t'($urandom),
                          target_t'($urandom), target_t'($urandom));
            else
                ticks = $urandom_range(1, 3);
            queue_ticks(ticks);
            counted += ticks;
        end
    endtask

    // Write the step register; the block is idle whenever this is called
    task automatic write_step(input logic [ssr_pkg::STEP_W-1:0] val);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        step_per_tick <= val;
        do
            @(negedge clk);
        while (!cfg_took);
        cfg_valid <= 1'b0;
        ramp_step = val;
    endtask

    // Wait for every transaction to be sent and answered, then let the pipe settle
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || cmd_hold || duty_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Input driver: present one transaction, hold it while stalled, then gap
    always @(negedge clk)
    begin : cmd_driver
        servo_cmd_t nxt;
        if (rst_n)
        begin
            if (in_took)
                cmd_hold = 1'b0;
            if (!cmd_hold)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (cmd_queue.size() != 0)
                begin
                    nxt = cmd_queue.pop_front();
                    op       <= nxt.op;
                    target_0 <= nxt.tgt[0];
                    target_1 <= nxt.tgt[1];
                    target_2 <= nxt.tgt[2];
                    target_3 <= nxt.tgt[3];
                    cmd_hold  = 1'b1;
                    send_wait = draw_wait();
                end
            end
            in_valid <= cmd_hold;
        end
    end

    // Result receiver: after each transaction, stall while a randomly drawn wait counts down
    always @(negedge clk)
    begin : result_stall
        if (rst_n)
        begin
            if (out_took)
                recv_wait = draw_wait();
            if (recv_wait > 0)
            begin
                out_stall <= 1'b1;
                recv_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Capture handshakes, predict accepted commands and check returned duties
    always @(posedge clk)
    begin : monitor
        servo_cmd_t seen;
        duty_set_t  want;
        duty_set_t  got;
        in_took  <= in_valid && !in_stall;
        out_took <= out_valid && !out_stall;
        cfg_took <= cfg_valid && cfg_ready;
        if (rst_n && in_valid && !in_stall)
        begin
            seen.op     = op;
            seen.tgt[0] = target_0;
            seen.tgt[1] = target_1;
            seen.tgt[2] = target_2;
            seen.tgt[3] = target_3;
            duty_expect_q.push_back(servo_advance(seen));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.duty[0] = duty_0;
            got.duty[1] = duty_1;
            got.duty[2] = duty_2;
            got.duty[3] = duty_3;
            got.moving  = moving;
            if (duty_expect_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got %0d %0d %0d %0d moving %0b",
                         $time, got.duty[0], got.duty[1], got.duty[2], got.duty[3],
                         got.moving);
                fault_count++;
            end
            else
            begin
                want = duty_expect_q.pop_front();
                for (int i = 0; i < ssr_pkg::CHANNELS; i++)
                begin
                    if (got.duty[i] !== want.duty[i])
                    begin
                        $display("%0t duty_%0d mismatch: expected %0d, got %0d",
                                 $time, i, want.duty[i], got.duty[i]);
                        fault_count++;
                    end
                end
                if (got.moving !== want.moving)
                begin
                    $display("%0t moving mismatch: expected %0b, got %0b",
                             $time, want.moving, got.moving);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= LIMIT_CYC)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        step_per_tick = '0;
        in_valid      = 1'b0;
        op            = ssr_pkg::OP_TICK;
        target_0      = '0;
        target_1      = '0;
        target_2      = '0;
        target_3      = '0;
        out_stall     = 1'b0;
        in_took       = 1'b0;
        out_took      = 1'b0;
        cfg_took      = 1'b0;
        cmd_hold      = 1'b0;
        send_wait     = 0;
        recv_wait     = 0;
        idle_on       = 1'b1;
        fault_count   = 0;
        cycle_count   = 0;
        ramp_step     = ssr_pkg::STEP_W'(STEP_RESET);
        for (int i = 0; i < ssr_pkg::CHANNELS; i++)
        begin
            ramp_pos[i]  = '0;
            ramp_aim[i]  = '0;
            ramp_duty[i] = ssr_pkg::duty_t'(ssr_pkg::DUTY_MID);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset step: idle tick, unused op, arm and hand near saturation
        queue_ticks(1);
        queue_cmd(OP_UNUSED, target_t'(-1), target_t'(-1), target_t'(-1), target_t'(-1));
        queue_cmd(ssr_pkg::OP_ARM, target_t'(ssr_pkg::HALF_PI_Q),
                  target_t'(-ssr_pkg::HALF_PI_Q), target_t'(100), target_t'(16383));
        queue_ticks(2);
        queue_cmd(ssr_pkg::OP_HAND, target_t'(16383), target_t'(16383), target_t'(16383),
                  target_t'(-16384));
        queue_ticks(2);
        wait_drained();

        // Full-scale step: field extremes reached in one or two ticks
        write_step('1);
        queue_cmd(ssr_pkg::OP_ARM, target_t'(16383), target_t'(-16384), target_t'(-1),
                  target_t'(0));
        queue_ticks(2);
        queue_cmd(ssr_pkg::OP_HAND, target_t'(0), target_t'(0), target_t'(0),
                  target_t'(16383));
        queue_ticks(3);
        wait_drained();

        // Zero step behaves as a step of one
        write_step('0);
        queue_cmd(ssr_pkg::OP_ARM, target_t'(1), target_t'(-1), target_t'(0), target_t'(0));
        queue_ticks(2);
        queue_cmd(ssr_pkg::OP_HAND, target_t'(0), target_t'(0), target_t'(0), target_t'(-1));
        queue_ticks(2);
        wait_drained();

        // Random traffic under a sweep of step settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_step(ssr_pkg::STEP_W'(1));
                1: write_step(ssr_pkg::STEP_W'(ssr_pkg::HALF_PI_Q));
                2: write_step(ssr_pkg::STEP_W'($urandom_range(2, 600)));
                3: write_step('1);
                4: write_step('0);
                default: write_step(ssr_pkg::STEP_W'($urandom_range(1, ssr_pkg::HALF_PI_Q)));
            endcase
            idle_on = (ph != 2);
            queue_random_traffic(PHASE_ITEMS);
            wait_drained();
        end

        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ssr_pkg.sv
hw/rtl/servo_slew_ramp_four_channel_unit.sv
test/tb_top.sv
